/* rtl/ipsbf_pkg.sv */
// Shared types and constants of the IPv4 source blocklist filter.
// No dependencies; every module of the block imports this package.
package ipsbf_pkg;

   localparam int EXACT_ENTRIES = 4096;
   localparam int EXACT_IDX_W   = $clog2(EXACT_ENTRIES);
   localparam int EXACT_CNT_W   = $clog2(EXACT_ENTRIES + 1);
   localparam int CIDR_ENTRIES  = 1024;
   localparam int CIDR_IDX_W    = $clog2(CIDR_ENTRIES);
   localparam int CIDR_PTR_W    = CIDR_IDX_W + 1;
   localparam int CIDR_SKIP     = 64;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;
   localparam logic [15:0] MIN_ETH_LEN  = 16'd14;
   localparam logic [15:0] MIN_IPV4_LEN = 16'd34;

   // Command codes.
   localparam logic [2:0] CMD_CLASSIFY = 3'd0;
   localparam logic [2:0] CMD_ADD      = 3'd1;
   localparam logic [2:0] CMD_REMOVE   = 3'd2;
   localparam logic [2:0] CMD_CIDR_WR  = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;

   // Categories.
   localparam logic [2:0] CAT_ALLOWED = 3'd0;
   localparam logic [2:0] CAT_EXACT   = 3'd1;
   localparam logic [2:0] CAT_CIDR    = 3'd2;
   localparam logic [2:0] CAT_IPV6    = 3'd3;
   localparam logic [2:0] CAT_NONIP   = 3'd4;
   localparam logic [2:0] CAT_COMMAND = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // Reasons.
   localparam logic [1:0] RSN_SQL  = 2'd1;
   localparam logic [1:0] RSN_RATE = 2'd2;

   // Counter indexes.
   localparam int CNT_TOTAL   = 0;
   localparam int CNT_BLOCKED = 1;
   localparam int CNT_ALLOWED = 2;
   localparam int CNT_IPV6    = 3;
   localparam int CNT_NONIP   = 4;
   localparam int CNT_SQL     = 5;
   localparam int CNT_RATE    = 6;
   localparam int CNT_MANUAL  = 7;
   localparam int NUM_COUNTERS = 8;

   // Work kinds decided by the front end.
   localparam logic [2:0] K_CLASSIFY = 3'd0;
   localparam logic [2:0] K_IPV6     = 3'd1;
   localparam logic [2:0] K_NONIP    = 3'd2;
   localparam logic [2:0] K_ADD      = 3'd3;
   localparam logic [2:0] K_REMOVE   = 3'd4;
   localparam logic [2:0] K_CIDR_WR  = 3'd5;
   localparam logic [2:0] K_READ     = 3'd6;
   localparam logic [2:0] K_NOP      = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [1:0]  reason;
      logic [9:0]  slot;
      logic [2:0]  cidx;
   } item_type;

endpackage

/* rtl/ipsbf_front.sv */
// Front end: accepts request words, classifies them by command and header,
// and holds them in a two-entry queue. Depends on ipsbf_pkg.
module ipsbf_front import ipsbf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [119:0]  req_tdata,
   output logic          item_valid,
   output item_type      item,
   input  logic          item_pop
);

   logic [2:0]  cmd;
   logic [15:0] flen;
   logic [15:0] etype;
   item_type    dec;

   item_type    q_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;

   assign cmd   = req_tdata[2:0];
   assign flen  = req_tdata[18:3];
   assign etype = req_tdata[34:19];

   always_comb begin
      dec.addr   = req_tdata[66:35];
      dec.mask   = req_tdata[98:67];
      dec.reason = req_tdata[100:99];
      dec.slot   = req_tdata[110:101];
      dec.cidx   = req_tdata[113:111];
      unique case (cmd)
         CMD_CLASSIFY: begin
            if (flen < MIN_ETH_LEN) dec.kind = K_NONIP;
            else if (etype == ETH_IPV4) dec.kind = (flen < MIN_IPV4_LEN) ? K_NONIP : K_CLASSIFY;
            else if (etype == ETH_IPV6) dec.kind = K_IPV6;
            else dec.kind = K_NONIP;
         end
         CMD_ADD:     dec.kind = K_ADD;
         CMD_REMOVE:  dec.kind = K_REMOVE;
         CMD_CIDR_WR: dec.kind = K_CIDR_WR;
         CMD_READ:    dec.kind = K_READ;
         default:     dec.kind = K_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ item_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= dec;
   end

endmodule

/* rtl/ipsbf_engine.sv */
// Back end: exact table (kept compacted under a fill count), CIDR table,
// statistics counters and the result register. Depends on ipsbf_pkg.
module ipsbf_engine import ipsbf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  item_type      item,
   output logic          item_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXSCAN = 3'd2;
   localparam logic [2:0] S_RMWAIT = 3'd3;
   localparam logic [2:0] S_CIDR   = 3'd4;

   logic [2:0] state_ff, state_in;
   item_type   cur_ff, cur_in;

   // Exact table: entries below the fill count are valid.
   logic [33:0] exact_mem [EXACT_ENTRIES];
   logic [33:0] ex_rd_ff;
   logic        ex_re, ex_we;
   logic [EXACT_IDX_W-1:0] ex_ra, ex_wa;
   logic [33:0] ex_wd;
   logic [EXACT_CNT_W-1:0] ex_count_ff, ex_count_in, ex_ptr_ff, ex_ptr_in;
   logic        ex_pend_ff;
   logic [EXACT_IDX_W-1:0] ex_pidx_ff, pos_ff, pos_in;
   logic        ex_hit, ex_miss;

   // CIDR table: {network, mask}.
   logic [63:0] cidr_mem [CIDR_ENTRIES];
   logic [63:0] c_rd_ff;
   logic        c_re, c_we;
   logic [CIDR_IDX_W-1:0] c_wa;
   logic [63:0] c_wd;
   logic [CIDR_PTR_W-1:0] c_ptr_ff, c_ptr_in;
   logic        c_pend_ff;
   logic [CIDR_IDX_W-1:0] c_pidx_ff;
   logic        c_hit, c_miss;
   logic [CIDR_IDX_W-1:0] clr_ff, clr_in;

   logic [63:0] cnt_ff [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0] bump;

   logic        fin;
   logic        fin_verdict;
   logic [2:0]  fin_cat;
   logic [1:0]  fin_status;
   logic [63:0] fin_value;
   logic        rvalid_ff, rvalid_in;
   logic [71:0] rdata_ff;

   assign item_pop = (state_ff == S_IDLE) && item_valid && (!rvalid_ff || rsp_tready);

   // Result of the exact scan, valid in the cycle after each read.
   assign ex_hit  = ex_pend_ff && (ex_rd_ff[33:2] == cur_ff.addr);
   assign ex_miss = !ex_pend_ff && !(ex_ptr_ff < ex_count_ff);

   // CIDR scan: empty slots are skipped in the low region and end the scan above it.
   always_comb begin
      c_hit  = 1'b0;
      c_miss = !c_pend_ff && (c_ptr_ff == CIDR_PTR_W'(CIDR_ENTRIES));
      if (c_pend_ff) begin
         if (c_rd_ff[63:32] == 32'd0) begin
            if (32'(c_pidx_ff) >= CIDR_SKIP) c_miss = 1'b1;
         end else if ((cur_ff.addr & c_rd_ff[31:0]) == c_rd_ff[63:32]) begin
            c_hit = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      ex_count_in = ex_count_ff;
      ex_ptr_in   = ex_ptr_ff;
      pos_in      = pos_ff;
      c_ptr_in    = c_ptr_ff;
      clr_in      = clr_ff;
      ex_re = 1'b0; ex_ra = ex_ptr_ff[EXACT_IDX_W-1:0];
      ex_we = 1'b0; ex_wa = '0; ex_wd = {cur_ff.addr, cur_ff.reason};
      c_re  = 1'b0;
      c_we  = 1'b0; c_wa = clr_ff; c_wd = '0;
      fin = 1'b0; fin_verdict = 1'b0; fin_cat = CAT_COMMAND;
      fin_status = ST_OK; fin_value = '0;
      bump = '0;
      unique case (state_ff)
         S_CLEAR: begin
            c_we   = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CIDR_IDX_W'(CIDR_ENTRIES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (item_pop) begin
               cur_in    = item;
               ex_ptr_in = '0;
               unique case (item.kind)
                  K_IPV6: begin
                     fin = 1'b1; fin_cat = CAT_IPV6;
                     bump[CNT_TOTAL] = 1'b1; bump[CNT_IPV6] = 1'b1;
                  end
                  K_NONIP: begin
                     fin = 1'b1; fin_cat = CAT_NONIP;
                     bump[CNT_TOTAL] = 1'b1; bump[CNT_NONIP] = 1'b1;
                  end
                  K_CIDR_WR: begin
                     c_we = 1'b1; c_wa = item.slot[CIDR_IDX_W-1:0];
                     c_wd = {item.addr, item.mask};
                     fin  = 1'b1;
                  end
                  K_READ: begin
                     fin = 1'b1; fin_value = cnt_ff[item.cidx];
                  end
                  K_NOP: fin = 1'b1;
                  default: state_in = S_EXSCAN;
               endcase
            end
         end
         S_EXSCAN: begin
            ex_re     = (ex_ptr_ff < ex_count_ff) && !ex_hit;
            ex_ptr_in = ex_re ? ex_ptr_ff + 1'b1 : ex_ptr_ff;
            if (ex_hit || ex_miss) begin
               unique case (cur_ff.kind)
                  K_CLASSIFY: begin
                     if (ex_hit) begin
                        fin = 1'b1; fin_verdict = 1'b1; fin_cat = CAT_EXACT;
                        bump[CNT_TOTAL] = 1'b1; bump[CNT_BLOCKED] = 1'b1;
                        if (ex_rd_ff[1:0] == RSN_SQL) bump[CNT_SQL] = 1'b1;
                        else if (ex_rd_ff[1:0] == RSN_RATE) bump[CNT_RATE] = 1'b1;
                        else bump[CNT_MANUAL] = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        c_ptr_in = '0;
                        state_in = S_CIDR;
                     end
                  end
                  K_ADD: begin
                     fin = 1'b1; state_in = S_IDLE;
                     if (ex_hit) begin
                        ex_we = 1'b1; ex_wa = ex_pidx_ff;
                     end else if (ex_count_ff == EXACT_CNT_W'(EXACT_ENTRIES)) begin
                        fin_status = ST_FULL;
                     end else begin
                        ex_we = 1'b1; ex_wa = ex_count_ff[EXACT_IDX_W-1:0];
                        ex_count_in = ex_count_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (ex_hit) begin
                        // Move the last entry into the hole.
                        pos_in   = ex_pidx_ff;
                        ex_re    = 1'b1;
                        ex_ra    = EXACT_IDX_W'(ex_count_ff - 1'b1);
                        state_in = S_RMWAIT;
                     end else begin
                        fin = 1'b1; fin_status = ST_NOT_FOUND; state_in = S_IDLE;
                     end
                  end
               endcase
            end
         end
         S_RMWAIT: begin
            ex_we = 1'b1; ex_wa = pos_ff; ex_wd = ex_rd_ff;
            ex_count_in = ex_count_ff - 1'b1;
            fin = 1'b1; state_in = S_IDLE;
         end
         S_CIDR: begin
            c_re     = (c_ptr_ff < CIDR_PTR_W'(CIDR_ENTRIES)) && !c_hit && !c_miss;
            c_ptr_in = c_re ? c_ptr_ff + 1'b1 : c_ptr_ff;
            if (c_hit) begin
               fin = 1'b1; fin_verdict = 1'b1; fin_cat = CAT_CIDR;
               bump[CNT_TOTAL] = 1'b1; bump[CNT_BLOCKED] = 1'b1;
               bump[CNT_MANUAL] = 1'b1;
               state_in = S_IDLE;
            end else if (c_miss) begin
               fin = 1'b1; fin_cat = CAT_ALLOWED;
               bump[CNT_TOTAL] = 1'b1; bump[CNT_ALLOWED] = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (fin) rvalid_in = 1'b1;
      else if (rsp_tready) rvalid_in = 1'b0;
      else rvalid_in = rvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         ex_count_ff <= '0;
         ex_pend_ff  <= 1'b0;
         c_pend_ff   <= 1'b0;
         rvalid_ff   <= 1'b0;
         for (int i = 0; i < NUM_COUNTERS; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         ex_count_ff <= ex_count_in;
         ex_pend_ff  <= ex_re && (state_ff == S_EXSCAN);
         c_pend_ff   <= c_re;
         rvalid_ff   <= rvalid_in;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (bump[i]) cnt_ff[i] <= cnt_ff[i] + 64'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      ex_ptr_ff  <= ex_ptr_in;
      pos_ff     <= pos_in;
      c_ptr_ff   <= c_ptr_in;
      ex_pidx_ff <= ex_ptr_ff[EXACT_IDX_W-1:0];
      c_pidx_ff  <= c_ptr_ff[CIDR_IDX_W-1:0];
      if (fin) rdata_ff <= {2'b00, fin_value, fin_status, fin_cat, fin_verdict};
   end

   always_ff @(posedge clock) begin
      if (ex_we) exact_mem[ex_wa] <= ex_wd;
      if (ex_re) ex_rd_ff <= exact_mem[ex_ra];
   end

   always_ff @(posedge clock) begin
      if (c_we) cidr_mem[c_wa] <= c_wd;
      if (c_re) c_rd_ff <= cidr_mem[c_ptr_ff[CIDR_IDX_W-1:0]];
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

endmodule

/* rtl/ipv4_source_blocklist_filter.sv */
// Top level of the IPv4 source blocklist filter: front end, queue and engine.
// Depends on ipsbf_pkg, ipsbf_front and ipsbf_engine.
//
//  Channel | Direction | Payload
//  req_    | in        | tdata: cmd, frame_length, ether_type, address, net_mask,
//          |           |        reason_kind, cidr_slot, counter_index
//  rsp_    | out       | tdata: verdict, category, op_status, counter_value
//
// Header-only items (IPv6, non-IP), CIDR writes and counter reads finish in
// the idle state without a scan. Exact lookups, adds and removes scan the
// filled part of the exact table one entry a cycle, and a remove then moves
// the last entry into the hole. An IPv4 miss then scans the CIDR table one
// slot a cycle. The single read port of each table sets these rates. After
// reset a clearing pass zeroes all 1024 slots of the CIDR table; the front
// queue still takes two words meanwhile. The queue lets requests land while a
// result waits on rsp_tready.
module ipv4_source_blocklist_filter import ipsbf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [2:0] cmd, [18:3] frame_length, [34:19] ether_type, [66:35] address,
   // [98:67] net_mask, [100:99] reason_kind, [110:101] cidr_slot,
   // [113:111] counter_index, [119:114] zero
   input  logic [119:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [0] verdict, [3:1] category, [5:4] op_status, [69:6] counter_value,
   // [71:70] zero
   output logic [71:0]   rsp_tdata
);

   item_type item;
   logic     item_valid;
   logic     item_pop;

   ipsbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   ipsbf_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Only blocked categories may carry a drop verdict.
   a_drop_cat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> (rsp_tdata[3:1] == CAT_EXACT || rsp_tdata[3:1] == CAT_CIDR))
      else $error("drop verdict with non-blocking category");

   // A counter value appears only on command results.
   a_value_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:1] != CAT_COMMAND) |-> (rsp_tdata[69:6] == 64'd0))
      else $error("counter value on a classify result");

   // Table status codes appear only on command results.
   a_status_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[5:4] != ST_OK) |-> (rsp_tdata[3:1] == CAT_COMMAND))
      else $error("status code on a classify result");

endmodule
